// ===== src/fraction_arith_reduce_core_macros.svh =====
// assertion macros shared by the fraction reduce rtl
// no dependencies, bodies are empty when SYNTHESIS is defined
`ifndef FRACTION_ARITH_REDUCE_CORE_MACROS_SVH
`define FRACTION_ARITH_REDUCE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define FRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fraction reduce: implication check failed");
`define FRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fraction reduce: next cycle check failed");
`else
`define FRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/frac_red_pkg.sv =====
// shared constants, op codes and controller/datapath command and status types
// no dependencies
package frac_red_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int NUM_BITS          = 34;
  localparam int DEN_BITS          = 33;

  typedef logic [1:0] op_t;
  localparam op_t OP_ADD = 2'd0;
  localparam op_t OP_SUB = 2'd1;
  localparam op_t OP_MUL = 2'd2;
  localparam op_t OP_DIV = 2'd3;

  typedef logic [1:0] mul_sel_t;
  localparam mul_sel_t MUL_P1  = 2'd0;
  localparam mul_sel_t MUL_P2  = 2'd1;
  localparam mul_sel_t MUL_DEN = 2'd2;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     combine;
    logic     gcd_init;
    logic     gcd_step;
    logic     g_form;
    logic     div_init;
    logic     div_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic dzero;
    logic gcd_done;
    logic out_free;
  } sts_t;

endpackage

// ===== src/frac_red_if.sv =====
// request channel interfaces: operand pair in, reduced fraction out
// depends on frac_red_pkg
interface frac_red_in_if #(parameter int OPERAND_WIDTH = 16);
  logic                            valid;
  logic                            ready;
  logic [1:0]                      op;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic signed [OPERAND_WIDTH-1:0] a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic signed [OPERAND_WIDTH-1:0] b_den;

  modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface frac_red_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [frac_red_pkg::NUM_BITS-1:0] res_num;
  logic [frac_red_pkg::DEN_BITS-1:0]        res_den;
  logic                                     status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

// ===== src/frac_red_ctrl.sv =====
// sequencing state machine: multiply, combine, binary gcd, divide, output
// depends on frac_red_pkg and the assertion macro header
`include "fraction_arith_reduce_core_macros.svh"

module frac_red_ctrl #(
  parameter int OPERAND_WIDTH = frac_red_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  frac_red_pkg::sts_t  sts_i,
  output frac_red_pkg::cmd_t  cmd_o
);
  import frac_red_pkg::*;

  localparam int MW = 2 * OPERAND_WIDTH;
  localparam int CW = $clog2(MW);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_COMB  = 3'd2;
  localparam logic [2:0] S_GINIT = 3'd3;
  localparam logic [2:0] S_GCD   = 3'd4;
  localparam logic [2:0] S_GFORM = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [4:0]    cmd_grp;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd_o     = '0;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cnt_r[1:0];
        if (cnt_r[1:0] == MUL_DEN) begin
          cnt_nxt   = '0;
          state_nxt = S_COMB;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_COMB: begin
        cmd_o.combine = 1'b1;
        state_nxt     = sts_i.dzero ? S_OUT : S_GINIT;
      end
      S_GINIT: begin
        cmd_o.gcd_init = 1'b1;
        state_nxt      = S_GCD;
      end
      S_GCD: begin
        if (sts_i.gcd_done) begin
          state_nxt = S_GFORM;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_GFORM: begin
        cmd_o.g_form   = 1'b1;
        cmd_o.div_init = 1'b1;
        cnt_nxt        = '0;
        state_nxt      = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_r == CW'(MW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign cmd_grp = {cmd_o.load, cmd_o.mul_en, cmd_o.gcd_step, cmd_o.div_step, cmd_o.out_load};

  `FRC_ASSERT_IMP(a_out_load_free, clk, rst_n, cmd_o.out_load, sts_i.out_free)
  `FRC_ASSERT_NXT(a_load_starts_mul, clk, rst_n, cmd_o.load, (state_r == S_MUL) && (cnt_r == '0))
  `FRC_ASSERT_IMP(a_cmd_exclusive, clk, rst_n, 1'b1, $onehot0(cmd_grp))

endmodule

// ===== src/frac_red_dp.sv =====
// datapath: operand split, shared multiplier, binary gcd, dual restoring divider
// depends on frac_red_pkg and the assertion macro header
`include "fraction_arith_reduce_core_macros.svh"

module frac_red_dp #(
  parameter int OPERAND_WIDTH = frac_red_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  frac_red_pkg::cmd_t                       cmd_i,
  output frac_red_pkg::sts_t                       sts_o,
  input  logic [1:0]                               in_op,
  input  logic signed [OPERAND_WIDTH-1:0]          in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0]          in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0]          in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0]          in_b_den,
  input  logic                                     out_ready,
  output logic                                     out_valid,
  output logic signed [frac_red_pkg::NUM_BITS-1:0] out_res_num,
  output logic [frac_red_pkg::DEN_BITS-1:0]        out_res_den,
  output logic                                     out_status
);
  import frac_red_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * W;
  localparam int KW = $clog2(MW + 1);

  op_t           op_r;
  logic          san_r, sad_r, sbn_r, sbd_r;
  logic [W-1:0]  an_r, ad_r, bn_r, bd_r;
  logic [W-1:0]  mul_x, mul_y;
  logic [MW-1:0] prod;
  logic [MW-1:0] p1_r, p2_r, d_r;
  logic [MW-1:0] nmag_r;
  logic          nneg_r, dneg_r;
  logic          s1, s2, dneg;
  logic [MW-1:0] nmag;
  logic          nneg;
  logic [MW-1:0] x_r, y_r, g_r;
  logic [KW-1:0] k_r;
  logic [MW-1:0] qn_r, qd_r, rn_r, rd_r;
  logic [MW:0]   tn, td, dn, dd;
  logic          gen, ged;
  logic          out_valid_r;
  logic signed [NUM_BITS-1:0] res_num_r;
  logic [DEN_BITS-1:0]        res_den_r;
  logic                       status_r;
  logic [MW+NUM_BITS-1:0]     qn_ext;
  logic [MW+DEN_BITS-1:0]     qd_ext;
  logic [NUM_BITS-1:0]        qn_fit;
  logic                       rneg;

  // operand capture as sign and magnitude
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op_r  <= in_op;
      san_r <= in_a_num[W-1];
      sad_r <= in_a_den[W-1];
      sbn_r <= in_b_num[W-1];
      sbd_r <= in_b_den[W-1];
      an_r  <= in_a_num[W-1] ? W'(~in_a_num + 1'b1) : W'(in_a_num);
      ad_r  <= in_a_den[W-1] ? W'(~in_a_den + 1'b1) : W'(in_a_den);
      bn_r  <= in_b_num[W-1] ? W'(~in_b_num + 1'b1) : W'(in_b_num);
      bd_r  <= in_b_den[W-1] ? W'(~in_b_den + 1'b1) : W'(in_b_den);
    end
  end

  // shared multiplier, one product per cycle
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_P1: begin
        mul_x = an_r;
        mul_y = (op_r == OP_MUL) ? bn_r : bd_r;
      end
      MUL_P2: begin
        mul_x = bn_r;
        mul_y = ad_r;
      end
      MUL_DEN: begin
        mul_x = ad_r;
        mul_y = (op_r == OP_DIV) ? bn_r : bd_r;
      end
      default: begin
        mul_x = an_r;
        mul_y = bd_r;
      end
    endcase
  end

  assign prod = MW'(mul_x) * MW'(mul_y);

  always_ff @(posedge clk) begin
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_sel)
        MUL_P1:  p1_r <= prod;
        MUL_P2:  p2_r <= prod;
        MUL_DEN: d_r  <= prod;
        default: p1_r <= prod;
      endcase
    end
  end

  // signed combine of the cross products
  assign s1   = san_r ^ ((op_r == OP_MUL) ? sbn_r : sbd_r);
  assign s2   = sbn_r ^ sad_r ^ (op_r == OP_SUB);
  assign dneg = sad_r ^ ((op_r == OP_DIV) ? sbn_r : sbd_r);

  always_comb begin
    nmag = p1_r;
    nneg = s1;
    if (op_r == OP_ADD || op_r == OP_SUB) begin
      priority if (s1 == s2) begin
        nmag = p1_r + p2_r;
      end else if (p1_r >= p2_r) begin
        nmag = p1_r - p2_r;
      end else begin
        nmag = p2_r - p1_r;
        nneg = s2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.combine) begin
      nmag_r <= nmag;
      nneg_r <= nneg;
      dneg_r <= dneg;
    end
  end

  // binary gcd, one step per cycle
  always_ff @(posedge clk) begin
    if (cmd_i.gcd_init) begin
      x_r <= nmag_r;
      y_r <= d_r;
      k_r <= '0;
    end else if (cmd_i.gcd_step) begin
      priority if (!x_r[0] && !y_r[0]) begin
        x_r <= x_r >> 1;
        y_r <= y_r >> 1;
        k_r <= k_r + KW'(1);
      end else if (!x_r[0]) begin
        x_r <= x_r >> 1;
      end else if (!y_r[0]) begin
        y_r <= y_r >> 1;
      end else if (x_r >= y_r) begin
        x_r <= (x_r - y_r) >> 1;
      end else begin
        y_r <= (y_r - x_r) >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.g_form) begin
      g_r <= (x_r | y_r) << k_r;
    end
  end

  // restoring division of numerator and denominator by the common factor
  assign tn  = {rn_r, qn_r[MW-1]};
  assign td  = {rd_r, qd_r[MW-1]};
  assign dn  = tn - {1'b0, g_r};
  assign dd  = td - {1'b0, g_r};
  assign gen = (tn >= {1'b0, g_r});
  assign ged = (td >= {1'b0, g_r});

  always_ff @(posedge clk) begin
    if (cmd_i.div_init) begin
      qn_r <= nmag_r;
      qd_r <= d_r;
      rn_r <= '0;
      rd_r <= '0;
    end else if (cmd_i.div_step) begin
      qn_r <= {qn_r[MW-2:0], gen};
      qd_r <= {qd_r[MW-2:0], ged};
      rn_r <= gen ? dn[MW-1:0] : tn[MW-1:0];
      rd_r <= ged ? dd[MW-1:0] : td[MW-1:0];
    end
  end

  // output register
  assign qn_ext = {{NUM_BITS{1'b0}}, qn_r};
  assign qd_ext = {{DEN_BITS{1'b0}}, qd_r};
  assign qn_fit = qn_ext[NUM_BITS-1:0];
  assign rneg   = (nneg_r != dneg_r) && (qn_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      if (sts_o.dzero) begin
        res_num_r <= '0;
        res_den_r <= '0;
        status_r  <= 1'b1;
      end else begin
        res_num_r <= rneg ? (~qn_fit + 1'b1) : qn_fit;
        res_den_r <= qd_ext[DEN_BITS-1:0];
        status_r  <= 1'b0;
      end
    end
  end

  assign sts_o.dzero    = (d_r == '0);
  assign sts_o.gcd_done = (x_r == '0) || (y_r == '0);
  assign sts_o.out_free = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;
  assign out_status  = status_r;

  `FRC_ASSERT_IMP(a_gcd_step_nonzero, clk, rst_n, cmd_i.gcd_step, (x_r != '0) && (y_r != '0))
  `FRC_ASSERT_NXT(a_div_rem_below_g, clk, rst_n, cmd_i.div_step, (rn_r < g_r) && (rd_r < g_r))
  `FRC_ASSERT_IMP(a_den_quot_nonzero, clk, rst_n, cmd_i.out_load && !sts_o.dzero, qd_r != '0)

endmodule

// ===== src/fraction_arith_reduce_core.sv =====
// A zero denominator skips the gcd and the divider and goes straight to the output state.
// Throughput: one request at a time; the next is taken once the result is registered,
// set by the shared gcd subtractor and the one-bit-per-cycle restoring divider.
// Reset: synchronous active-low rst_n clears the state machine and output valid.
module fraction_arith_reduce_core #(
  parameter int OPERAND_WIDTH = frac_red_pkg::OPERAND_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  frac_red_in_if.sink       in_chan,
  frac_red_out_if.source    out_chan
);
  import frac_red_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  frac_red_ctrl #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  frac_red_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_op       (in_chan.op),
    .in_a_num    (in_chan.a_num),
    .in_a_den    (in_chan.a_den),
    .in_b_num    (in_chan.b_num),
    .in_b_den    (in_chan.b_den),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_res_num (out_chan.res_num),
    .out_res_den (out_chan.res_den),
    .out_status  (out_chan.status)
  );

  assign in_chan.ready = in_ready;

endmodule
